// ===== design/bsc_pkg.sv =====
package bsc_pkg;

    localparam int NOW_W    = 32;
    localparam int ID_W     = 16;
    localparam int IVL_W    = 16;
    localparam int HUE_W    = 8;
    localparam int BIAS_W   = 7;
    localparam int RAMP_W   = 3;
    localparam int PERIOD_W = 16;

    // Divisor of the period division: sections (up to 255) times ramp level plus one (up to 8).
    localparam int DEN_W = 11;

    localparam logic [IVL_W-1:0] INTERVAL_RST = 16'd30000;

    // Multiplying by 43691 and dropping 17 bits divides any 16-bit value by three exactly.
    localparam logic [16:0] THIRD_RECIP = 17'd43691;
    localparam int          THIRD_SHIFT = 17;

    localparam logic [BIAS_W-1:0] WEIGHT_TAB [8] = '{
        7'd0, 7'd0, 7'd50, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90
    };

    localparam logic [0:0] REG_OWN_ID   = 1'b0;
    localparam logic [0:0] REG_INTERVAL = 1'b1;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             beacon_valid;
        logic [ID_W-1:0]  beacon_id;
    } upd_t;

    typedef struct packed {
        logic                wing_flash;
        logic                hue_valid;
        logic [HUE_W-1:0]    hue_value;
        logic                send_beacon;
        logic                weight_valid;
        logic [BIAS_W-1:0]   bias_weight;
        logic [PERIOD_W-1:0] hue_period_out;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_BUMP,
        S_DIV1,
        S_TICK,
        S_DIV2,
        S_DONE
    } state_t;

endpackage

// ===== design/beacon_sync_clock_pair.sv =====
// Beacon-synchronized clock pair. Each update word carries the current
// millisecond time and an optional received beacon ID; each update yields
// exactly one result word with the wing flash, hue tick, beacon send and bias
// weight events plus the hue period in force after the update.
// Both channels use valid/stall: a word moves on a rising edge where valid is
// high and stall is low. The configuration port (cfg_we, cfg_index,
// cfg_data) writes own_id (index 0) or beacon_interval_ms (index 1),
// and must only be used while the block is idle.
// An update is taken, then worked through a small sequencer. Without a
// foreign beacon or beacon tick it passes MUL, TICK and DONE. A foreign
// beacon adds BUMP, which applies the one-third bump, and DIV1; a beacon tick
// adds DIV2. The shared radix-2 divider runs in DIV1 and DIV2, once for each
// period recomputation. upd_stall is high from acceptance until the result
// is registered, so no new update is taken before the last one is through.
// A finished result sits in an output register and the next update is taken
// while it waits; if the receiver still stalls when the next result is done,
// the sequencer holds in its last state until the output register frees up.
// Reset clears the sequencer and restores the power-up state: interval 30000,
// hue period interval/HUE_SECTIONS, ramp level and hue clock at zero.
module beacon_sync_clock_pair #(
    parameter int RAMP_TOP     = 4,
    parameter int HUE_SECTIONS = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         upd_valid,
    output logic                         upd_stall,
    input  bsc_pkg::upd_t                upd,
    output logic                         res_valid,
    input  logic                         res_stall,
    output bsc_pkg::res_t                res,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [bsc_pkg::IVL_W-1:0]    cfg_data
);

    localparam int NOW_W    = bsc_pkg::NOW_W;
    localparam int IVL_W    = bsc_pkg::IVL_W;
    localparam int HUE_W    = bsc_pkg::HUE_W;
    localparam int RAMP_W   = bsc_pkg::RAMP_W;
    localparam int PERIOD_W = bsc_pkg::PERIOD_W;
    localparam int DEN_W    = bsc_pkg::DEN_W;
    localparam int CNT_W    = $clog2(IVL_W);
    localparam int HUE_STEP = 255 / HUE_SECTIONS;
    localparam logic [PERIOD_W-1:0] RST_PERIOD =
        PERIOD_W'(int'(bsc_pkg::INTERVAL_RST) / HUE_SECTIONS);

    // Hue step value for every hue clock position: (count mod sections) * step.
    logic [HUE_W-1:0] hue_tab [256];
    for (genvar g = 0; g < 256; g++)
    begin : g_hue_tab
        assign hue_tab[g] = HUE_W'((g % HUE_SECTIONS) * HUE_STEP);
    end

    bsc_pkg::state_t state_reg, state_next;

    logic [IVL_W-1:0]    own_id_reg, own_id_next;
    logic [IVL_W-1:0]    interval_reg, interval_next;
    logic [HUE_W-1:0]    hue_count_reg, hue_count_next;
    logic [PERIOD_W-1:0] hue_period_reg, hue_period_next;
    logic [NOW_W-1:0]    last_hue_reg, last_hue_next;
    logic [NOW_W-1:0]    last_beacon_reg, last_beacon_next;
    logic [RAMP_W-1:0]   ramp_reg, ramp_next;

    logic [NOW_W-1:0]    now_reg, now_next;
    logic                foreign_reg, foreign_next;
    logic [IVL_W-1:0]    bump_reg, bump_next;
    bsc_pkg::res_t       acc_reg, acc_next;

    // Shared divider.
    logic [DEN_W-1:0]    div_rem_reg, div_rem_next;
    logic [IVL_W-1:0]    div_quo_reg, div_quo_next;
    logic [DEN_W-1:0]    div_den_reg, div_den_next;
    logic [CNT_W-1:0]    div_cnt_reg, div_cnt_next;

    logic                res_valid_reg, res_valid_next;
    bsc_pkg::res_t       res_reg, res_next;

    logic                upd_take;
    logic                out_free;
    logic                div_last;
    logic [DEN_W:0]      div_shift;
    logic                div_bit;
    logic [IVL_W-1:0]    div_quo_step;
    logic [DEN_W-1:0]    div_rem_step;
    logic [32:0]         third_prod;
    logic [RAMP_W-1:0]   ramp_up;
    logic [RAMP_W-1:0]   ramp_down;
    logic                hue_hit;
    logic                beacon_hit;

    assign upd_stall = (state_reg != bsc_pkg::S_IDLE);
    assign upd_take  = upd_valid && !upd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    assign div_shift    = {div_rem_reg, div_quo_reg[IVL_W-1]};
    assign div_bit      = (div_shift >= {1'b0, div_den_reg});
    assign div_rem_step = div_bit ? DEN_W'(div_shift - {1'b0, div_den_reg})
                                  : div_shift[DEN_W-1:0];
    assign div_quo_step = {div_quo_reg[IVL_W-2:0], div_bit};
    assign div_last     = (div_cnt_reg == CNT_W'(IVL_W - 1));

    assign third_prod = 33'(interval_reg) * 33'(bsc_pkg::THIRD_RECIP);

    assign ramp_up   = (int'(ramp_reg) < RAMP_TOP) ? RAMP_W'(ramp_reg + 1'b1)
                                                   : RAMP_W'(RAMP_TOP);
    assign ramp_down = (ramp_reg != '0) ? RAMP_W'(ramp_reg - 1'b1) : ramp_reg;

    // Tick tests use wrapping 32-bit elapsed time.
    assign hue_hit    = (NOW_W'(now_reg - last_hue_reg) >= NOW_W'(hue_period_reg));
    assign beacon_hit = (NOW_W'(now_reg - last_beacon_reg) > NOW_W'(interval_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsc_pkg::S_IDLE:
            begin
                if (upd_take)
                begin
                    state_next = bsc_pkg::S_MUL;
                end
            end
            bsc_pkg::S_MUL:
            begin
                state_next = foreign_reg ? bsc_pkg::S_BUMP : bsc_pkg::S_TICK;
            end
            bsc_pkg::S_BUMP:
            begin
                state_next = bsc_pkg::S_DIV1;
            end
            bsc_pkg::S_DIV1:
            begin
                if (div_last)
                begin
                    state_next = bsc_pkg::S_TICK;
                end
            end
            bsc_pkg::S_TICK:
            begin
                state_next = beacon_hit ? bsc_pkg::S_DIV2 : bsc_pkg::S_DONE;
            end
            bsc_pkg::S_DIV2:
            begin
                if (div_last)
                begin
                    state_next = bsc_pkg::S_DONE;
                end
            end
            bsc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bsc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bsc_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and output register.
    always_comb
    begin
        own_id_next      = own_id_reg;
        interval_next    = interval_reg;
        hue_count_next   = hue_count_reg;
        hue_period_next  = hue_period_reg;
        last_hue_next    = last_hue_reg;
        last_beacon_next = last_beacon_reg;
        ramp_next        = ramp_reg;
        now_next         = now_reg;
        foreign_next     = foreign_reg;
        bump_next        = bump_reg;
        acc_next         = acc_reg;
        div_rem_next     = div_rem_reg;
        div_quo_next     = div_quo_reg;
        div_den_next     = div_den_reg;
        div_cnt_next     = div_cnt_reg;
        res_valid_next   = res_valid_reg;
        res_next         = res_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::REG_OWN_ID:   own_id_next   = cfg_data;
                bsc_pkg::REG_INTERVAL: interval_next = cfg_data;
                default:               ;
            endcase
        end

        case (state_reg)
            bsc_pkg::S_IDLE:
            begin
                if (upd_take)
                begin
                    now_next     = upd.now_ms;
                    foreign_next = upd.beacon_valid && (upd.beacon_id != own_id_reg);
                    acc_next     = '0;
                end
            end
            bsc_pkg::S_MUL:
            begin
                bump_next = third_prod[32:bsc_pkg::THIRD_SHIFT];
            end
            bsc_pkg::S_BUMP:
            begin
                ramp_next             = ramp_up;
                last_beacon_next      = NOW_W'(last_beacon_reg - NOW_W'(bump_reg));
                acc_next.wing_flash   = 1'b1;
                acc_next.weight_valid = 1'b1;
                acc_next.bias_weight  = bsc_pkg::WEIGHT_TAB[ramp_up];
                div_rem_next          = '0;
                div_quo_next          = IVL_W'(interval_reg - bump_reg);
                div_den_next          = DEN_W'(HUE_SECTIONS) *
                                        (DEN_W'(ramp_up) + DEN_W'(1));
                div_cnt_next          = '0;
            end
            bsc_pkg::S_DIV1, bsc_pkg::S_DIV2:
            begin
                div_rem_next = div_rem_step;
                div_quo_next = div_quo_step;
                div_cnt_next = CNT_W'(div_cnt_reg + 1'b1);
                if (div_last)
                begin
                    hue_period_next = PERIOD_W'(div_quo_step);
                end
            end
            bsc_pkg::S_TICK:
            begin
                if (hue_hit)
                begin
                    last_hue_next      = now_reg;
                    acc_next.hue_valid = 1'b1;
                    acc_next.hue_value = hue_tab[hue_count_reg];
                    hue_count_next     = HUE_W'(hue_count_reg + HUE_W'(HUE_STEP));
                end
                if (beacon_hit)
                begin
                    last_beacon_next      = now_reg;
                    last_hue_next         = now_reg;
                    hue_count_next        = '0;
                    ramp_next             = ramp_down;
                    acc_next.send_beacon  = 1'b1;
                    acc_next.weight_valid = 1'b1;
                    acc_next.bias_weight  = bsc_pkg::WEIGHT_TAB[ramp_down];
                    div_rem_next          = '0;
                    div_quo_next          = interval_reg;
                    div_den_next          = DEN_W'(HUE_SECTIONS) *
                                            (DEN_W'(ramp_down) + DEN_W'(1));
                    div_cnt_next          = '0;
                end
            end
            bsc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next          = 1'b1;
                    res_next                = acc_reg;
                    res_next.hue_period_out = hue_period_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bsc_pkg::S_IDLE;
            own_id_reg      <= '0;
            interval_reg    <= bsc_pkg::INTERVAL_RST;
            hue_count_reg   <= '0;
            hue_period_reg  <= RST_PERIOD;
            last_hue_reg    <= NOW_W'(RST_PERIOD);
            last_beacon_reg <= NOW_W'(bsc_pkg::INTERVAL_RST);
            ramp_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            own_id_reg      <= own_id_next;
            interval_reg    <= interval_next;
            hue_count_reg   <= hue_count_next;
            hue_period_reg  <= hue_period_next;
            last_hue_reg    <= last_hue_next;
            last_beacon_reg <= last_beacon_next;
            ramp_reg        <= ramp_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        foreign_reg <= foreign_next;
        bump_reg    <= bump_next;
        acc_reg     <= acc_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        res_reg     <= res_next;
    end

endmodule

// ===== design/bsc_chk.sv =====
module bsc_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          upd_valid,
    input logic          upd_stall,
    input logic          res_valid,
    input logic          res_stall,
    input bsc_pkg::res_t res
);

    // A stalled result word stays put.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // An accepted update keeps the input side busy in the next cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && !upd_stall |=> upd_stall)
        else $error("update side not busy after taking a word");

    a_hue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hue_valid |-> res.hue_value == '0)
        else $error("hue value set without a hue tick");

    a_bias_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.weight_valid |-> res.bias_weight == '0)
        else $error("bias weight set without a ramp evaluation");

    a_bias_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.bias_weight <= 7'd90)
        else $error("bias weight out of range");

endmodule

bind beacon_sync_clock_pair bsc_chk u_bsc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_valid (upd_valid),
    .upd_stall (upd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ===== tb/tb_beacon_sync_clock_pair.sv =====
module tb_beacon_sync_clock_pair;

    // Block parameters, kept at the values the predictor below assumes.
    localparam int unsigned RAMP_TOP     = 4;
    localparam int unsigned HUE_SECTIONS = 5;
    localparam int unsigned HUE_STEP     = 255 / HUE_SECTIONS;

    // The slowest update is a foreign beacon plus a beacon tick, so
    // this many quiet cycles are enough for any straggling word to show up.
    localparam int SETTLE_CYCLES = 60;

    // Bias weight per ramp level; levels 3 and above stay at 90.
    localparam logic [bsc_pkg::BIAS_W-1:0] BIAS_OF_LEVEL [8] = '{
        7'd0, 7'd0, 7'd50, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90
    };

    // One update word waiting to be sent. When hold_for_drain is set, the
    // sender stays quiet until every predicted result has come back first.
    typedef struct {
        bsc_pkg::upd_t word;
        bit            hold_for_drain;
    } update_req_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         upd_valid = 1'b0;
    logic                         upd_stall;
    bsc_pkg::upd_t                upd = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    bsc_pkg::res_t                res;
    logic                         cfg_we = 1'b0;
    logic [0:0]                   cfg_index = bsc_pkg::REG_OWN_ID;
    logic [bsc_pkg::IVL_W-1:0]    cfg_data = '0;

    // Predictor copy of the registers and of the hue and beacon clocks.
    logic [bsc_pkg::ID_W-1:0]     node_id;
    logic [bsc_pkg::IVL_W-1:0]    beacon_ivl;
    logic [bsc_pkg::HUE_W-1:0]    hue_clock;
    logic [bsc_pkg::PERIOD_W-1:0] hue_period;
    logic [bsc_pkg::NOW_W-1:0]    last_hue_ms;
    logic [bsc_pkg::NOW_W-1:0]    last_beacon_ms;
    logic [bsc_pkg::RAMP_W-1:0]   ramp_level;

    update_req_t                  update_backlog[$];
    bsc_pkg::res_t                predicted_res[$];
    int                           words_queued = 0;
    int                           words_taken = 0;
    int                           results_seen = 0;
    int                           err_count = 0;

    // Sender pacing.
    int                           burst_left = 0;
    int                           gap_left = 0;
    update_req_t                  next_req;

    // Receiver stall pattern.
    int                           stall_mode = 0;
    int                           stall_left = 0;
    int                           stall_tick = 0;
    bsc_pkg::res_t                want;

    always #4 clk = ~clk;

    beacon_sync_clock_pair #(
        .RAMP_TOP     (RAMP_TOP),
        .HUE_SECTIONS (HUE_SECTIONS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd_valid),
        .upd_stall (upd_stall),
        .upd       (upd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Hue period for a given span at the current ramp level, cut to 16 bits.
    function automatic logic [bsc_pkg::PERIOD_W-1:0] period_of(input logic [31:0] span);
        logic [31:0] p;
        p = (span / HUE_SECTIONS) / (32'(ramp_level) + 32'd1);
        return p[bsc_pkg::PERIOD_W-1:0];
    endfunction

    // Applies one update word to the predictor state and returns the result
    // word the block must produce for it. The order matters: beacon handling
    // first, then the hue tick, then the beacon tick.
    function automatic bsc_pkg::res_t advance_clocks(input bsc_pkg::upd_t u);
        bsc_pkg::res_t r;
        logic [31:0]   ivl;
        logic [31:0]   third;
        logic [31:0]   since_hue;
        logic [31:0]   since_beacon;
        r = '0;
        ivl = 32'(beacon_ivl);

        // A foreign beacon pulls the next beacon tick closer by a third of the
        // interval and shortens the hue period for the raised ramp level.
        if (u.beacon_valid && u.beacon_id != node_id)
        begin
            if (32'(ramp_level) < RAMP_TOP)
                ramp_level = ramp_level + 3'd1;
            r.bias_weight = BIAS_OF_LEVEL[ramp_level];
            r.weight_valid = 1'b1;
            third = ivl / 32'd3;
            last_beacon_ms = last_beacon_ms - third;
            hue_period = period_of(ivl - third);
            r.wing_flash = 1'b1;
        end

        // Elapsed times are taken modulo 2^32 so that the time may wrap.
        since_hue = u.now_ms - last_hue_ms;
        if (since_hue >= 32'(hue_period))
        begin
            last_hue_ms = u.now_ms;
            r.hue_value = 8'((32'(hue_clock) % HUE_SECTIONS) * HUE_STEP);
            r.hue_valid = 1'b1;
            hue_clock = hue_clock + 8'(HUE_STEP);
        end

        // The beacon tick restarts both clocks and lowers the ramp level; its
        // bias weight replaces the one of a beacon in the same update.
        since_beacon = u.now_ms - last_beacon_ms;
        if (since_beacon > ivl)
        begin
            last_beacon_ms = u.now_ms;
            r.send_beacon = 1'b1;
            hue_clock = '0;
            last_hue_ms = u.now_ms;
            if (ramp_level != 0)
                ramp_level = ramp_level - 3'd1;
            hue_period = period_of(ivl);
            r.bias_weight = BIAS_OF_LEVEL[ramp_level];
            r.weight_valid = 1'b1;
        end

        r.hue_period_out = hue_period;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 50)
            $display("MISMATCH: %s", what);
    endtask

    task automatic check_field(input string field, input int unsigned got,
                               input int unsigned exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, field, got, exp_val));
    endtask

    // Sender. A new word is put on the bus only when the slot is free, that
    // is when nothing is driven or the current word was just taken, so the
    // valid line never reacts combinationally to the stall line.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_valid <= 1'b0;
            upd <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (upd_valid && !upd_stall)
            begin
                predicted_res.push_back(advance_clocks(upd));
                words_taken++;
            end
            if (!upd_valid || !upd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    upd_valid <= 1'b0;
                end
                else if (update_backlog.size() > 0 &&
                         !(update_backlog[0].hold_for_drain && predicted_res.size() != 0))
                begin
                    next_req = update_backlog.pop_front();
                    upd <= next_req.word;
                    upd_valid <= 1'b1;
                    // At the end of a burst pick the next gap and burst length.
                    // A zero gap runs two bursts together with no idle at all.
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 5);
                            default: gap_left = $urandom_range(10, 50);
                        endcase
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    upd_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every word taken is checked against the oldest prediction.
    // The stall line follows its own pattern, switching between no stall,
    // light random stall, heavy random stall and a periodic stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
            stall_tick = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (predicted_res.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with none predicted",
                                              results_seen));
                end
                else
                begin
                    want = predicted_res.pop_front();
                    check_field("wing_flash", res.wing_flash, want.wing_flash);
                    check_field("hue_valid", res.hue_valid, want.hue_valid);
                    check_field("hue_value", res.hue_value, want.hue_value);
                    check_field("send_beacon", res.send_beacon, want.send_beacon);
                    check_field("weight_valid", res.weight_valid, want.weight_valid);
                    check_field("bias_weight", res.bias_weight, want.bias_weight);
                    check_field("hue_period_out", res.hue_period_out,
                                want.hue_period_out);
                end
            end

            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(10, 200);
            end
            else
            begin
                stall_left--;
            end
            stall_tick++;
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                2:       res_stall <= ($urandom_range(0, 7) != 0);
                default: res_stall <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    task automatic queue_word(input logic [bsc_pkg::NOW_W-1:0] now_ms, input logic bv,
                              input logic [bsc_pkg::ID_W-1:0] id, input bit hold);
        update_req_t req;
        req.word.now_ms = now_ms;
        req.word.beacon_valid = bv;
        req.word.beacon_id = id;
        req.hold_for_drain = hold;
        update_backlog.push_back(req);
        words_queued++;
    endtask

    // Waits until every queued word was taken and every predicted result has
    // come back, then lets the block settle.
    task automatic wait_drained();
        while (words_taken != words_queued || predicted_res.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register and mirrors it in the predictor. The write enable
    // is left high; run_phase lowers it after the last write.
    task automatic write_reg(input logic [0:0] idx,
                             input logic [bsc_pkg::IVL_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == bsc_pkg::REG_OWN_ID)
            node_id = value;
        else
            beacon_ivl = value;
    endtask

    // One phase: new register settings, then a run of random updates. Most
    // updates step the time forward by a fraction of the interval so that hue
    // ticks, beacon ticks and foreign beacons interleave; a few jump to a
    // random time or close to the wrap point. Halfway through, the sender
    // waits until the block has answered everything.
    task automatic run_phase(input logic [bsc_pkg::ID_W-1:0] own,
                             input logic [bsc_pkg::IVL_W-1:0] ivl, input int count);
        logic [bsc_pkg::NOW_W-1:0] run_ms;
        logic                      bv;
        logic [bsc_pkg::ID_W-1:0]  id;
        int unsigned               pick;
        write_reg(bsc_pkg::REG_OWN_ID, own);
        write_reg(bsc_pkg::REG_INTERVAL, ivl);
        @(posedge clk);
        cfg_we <= 1'b0;
        run_ms = $urandom();
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                run_ms = run_ms + $urandom_range(0, 32'(beacon_ivl) / 8 + 1);
            else if (pick < 92)
                run_ms = run_ms + $urandom_range(0, 32'(beacon_ivl) + 2);
            else if (pick < 97)
                run_ms = $urandom();
            else
                run_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * 32'(beacon_ivl));
            bv = ($urandom_range(0, 99) < 35);
            id = ($urandom_range(0, 3) == 0) ? node_id : 16'($urandom());
            queue_word(run_ms, bv, id, k == count / 2);
        end
        wait_drained();
    endtask

    initial
    begin
        // Predictor state after reset: interval 30000, hue period 6000.
        node_id = '0;
        beacon_ivl = bsc_pkg::INTERVAL_RST;
        hue_clock = '0;
        ramp_level = '0;
        hue_period = period_of(32'(bsc_pkg::INTERVAL_RST));
        last_hue_ms = 32'(hue_period);
        last_beacon_ms = 32'(bsc_pkg::INTERVAL_RST);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset settings (own ID 0, interval 30000).
        // Time zero with an empty beacon, then the block's own beacon, which
        // must be ignored, and a foreign ID with the valid bit low.
        queue_word(32'h0000_0000, 1'b0, 16'h0000, 1'b0);
        queue_word(32'd100, 1'b1, 16'h0000, 1'b0);
        queue_word(32'd200, 1'b0, 16'hFFFF, 1'b0);
        // Back-to-back foreign beacons: every third one forces a beacon tick
        // in the same update, and the ramp level climbs into saturation.
        for (int k = 0; k < 9; k++)
            queue_word(32'd300 + 32'(k) * 32'd10, 1'b1, 16'hFFFF ^ 16'(k), 1'b0);
        // With the short hue period at a high ramp level, steady steps give
        // enough hue ticks for the hue clock to wrap past 255.
        for (int k = 1; k <= 8; k++)
            queue_word(32'd400 + 32'(k) * 32'd1600, 1'b0, 16'h0000, 1'b0);
        // Largest time with a foreign beacon, the same time again with
        // nothing to do, and a jump to the middle of the range.
        queue_word(32'hFFFF_FFFF, 1'b1, 16'h8001, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b1);
        queue_word(32'h8000_0000, 1'b1, 16'h7FFE, 1'b0);
        wait_drained();

        // Random phases across several settings, the extremes among them.
        run_phase(16'hFFFF, 16'd65535, 230);
        run_phase(16'h0000, 16'd1, 230);
        run_phase(16'($urandom()), 16'($urandom_range(2, 200)), 230);
        run_phase(16'($urandom()), 16'd30000, 230);
        run_phase(16'($urandom()), 16'($urandom_range(1, 65535)), 230);
        run_phase(16'h5A5A, 16'd7, 230);

        if (err_count == 0)
            $display("** beacon_sync_clock_pair: PASSED **");
        else
            $display("** beacon_sync_clock_pair: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #8000000;
        $display("** beacon_sync_clock_pair: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bsc_pkg.sv
design/beacon_sync_clock_pair.sv
design/bsc_chk.sv
tb/tb_beacon_sync_clock_pair.sv
